// ===== sv/keyword_occurrence_counter_unit_defines.svh =====
// Assertion macros for the keyword counter top file.
`ifndef KEYWORD_OCCURRENCE_COUNTER_UNIT_DEFINES_SVH
`define KEYWORD_OCCURRENCE_COUNTER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KOC_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("keyword counter: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define KOC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("keyword counter: next-cycle check failed");

`endif

// ===== sv/koc_pkg.sv =====
`default_nettype none
package koc_pkg;

  localparam int NUM_KEYS = 128;
  localparam int KEY_LEN  = 32;

  localparam int KIDX_W  = $clog2(NUM_KEYS);
  localparam int POS_W   = $clog2(KEY_LEN);
  localparam int WP_W    = $clog2(KEY_LEN + 1);
  localparam int KADDR_W = KIDX_W + POS_W;
  localparam int CNT_W   = 32;

  // Field widths on the ports.
  localparam int IDX_FW  = 7;
  localparam int CPOS_FW = 5;
  localparam int VAL_FW  = 8;
  localparam int KIND_FW = 3;
  localparam int IN_TW   = 24;
  localparam int OUT_TW  = 40;

  localparam logic [KIND_FW-1:0] KIND_KEY_WR = 3'd0;
  localparam logic [KIND_FW-1:0] KIND_TEXT   = 3'd1;
  localparam logic [KIND_FW-1:0] KIND_EOT    = 3'd2;
  localparam logic [KIND_FW-1:0] KIND_RD_CNT = 3'd3;
  localparam logic [KIND_FW-1:0] KIND_CLR    = 3'd4;

  typedef struct packed {
    logic accept;
    logic key_wr;
    logic clr_step;
    logic kill_all;
    logic restart;
    logic ctr_clr;
    logic key_rd;
    logic ltr_cmp;
    logic word_inc;
    logic ctr_rd;
    logic rd_item;
    logic cls_upd;
    logic k_clr;
    logic k_inc;
    logic out_ld;
  } koc_cmd_t;

  typedef struct packed {
    logic [KIND_FW-1:0] kind;
    logic               is_letter;
    logic               word_empty;
    logic               word_full;
    logic               last_key;
    logic               clr_last;
  } koc_sts_t;

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    return (c > 8'd90) ? (c - 8'd32) : c;
  endfunction

endpackage
`default_nettype wire

// ===== sv/keyword_occurrence_counter_unit.sv =====
// Channel | Dir | Beat contents
// s_*     | in  | tuser: kind[2:0]; tdata: key_index[6:0], char_pos[11:7], value[19:12]
// m_*     | out | tdata: key_index_out[6:0], match_count[38:7]
//
// After reset a clearing pass zeroes the 4096-entry key table;
// no beat is accepted until it ends.
// Key writes, count clears and empty word closes finish in the accepting cycle.
// A letter runs as the accepting cycle, then a key read and a compare for each of
// the 128 slots in turn; a letter past the key length only clears all matches.
// A word close runs as the accepting cycle, then read and counter update per slot.
// A count read passes through S_CNT_RD and S_OUT; it waits longer only while an earlier result is still held.
`default_nettype none
`include "keyword_occurrence_counter_unit_defines.svh"
module keyword_occurrence_counter_unit
  import koc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_tvalid,
  output logic                    s_tready,
  input  wire logic [IN_TW-1:0]   s_tdata,  // key_index, char_pos, value
  input  wire logic [KIND_FW-1:0] s_tuser,  // kind
  output logic                    m_tvalid,
  input  wire logic               m_tready,
  output logic [OUT_TW-1:0]       m_tdata   // key_index_out, match_count
);

  koc_cmd_t cmd;
  koc_sts_t sts;

  koc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  koc_dpath u_dpath (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .sts     (sts),
    .m_tdata (m_tdata)
  );

  // A stalled result beat stays valid and unchanged.
  `KOC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  // A count read leaves the input closed on the next cycle.
  `KOC_ASSERT_NEXT(a_read_busy, s_tvalid && s_tready && (s_tuser == KIND_RD_CNT), !s_tready)
  // Only one key table write source at a time.
  `KOC_ASSERT_IMPLY(a_one_writer, cmd.clr_step, !cmd.key_wr)

endmodule
`default_nettype wire

// ===== sv/koc_dpath.sv =====
`default_nettype none
module koc_dpath
  import koc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire koc_cmd_t          cmd,
  input  wire logic [IN_TW-1:0]  s_tdata,
  input  wire logic [KIND_FW-1:0] s_tuser,
  output koc_sts_t               sts,
  output logic [OUT_TW-1:0]      m_tdata
);

  logic [7:0]        key_mem [2**KADDR_W];
  logic [CNT_W-1:0]  ctr_mem [NUM_KEYS];
  logic [NUM_KEYS-1:0] ctr_vld;
  logic [NUM_KEYS-1:0] still;
  logic [WP_W-1:0]   word_pos;
  logic [KIDX_W-1:0] kcnt;
  logic [KADDR_W-1:0] clr_cnt;
  logic [7:0]        letter;
  logic [IDX_FW-1:0] item_idx;
  logic              item_oob;
  logic [7:0]        rd_a;
  logic [7:0]        rd_b;
  logic [CNT_W-1:0]  ctr_q;

  logic [IDX_FW-1:0]  in_idx;
  logic [CPOS_FW-1:0] in_pos;
  logic [VAL_FW-1:0]  in_val;
  logic               in_ok;
  logic [KADDR_W-1:0] wr_addr;
  logic [7:0]         wr_data;
  logic               wr_en;
  logic [KIDX_W-1:0]  ctr_addr;
  logic               hit;

  // Unpack the input beat.
  assign in_idx = s_tdata[IDX_FW-1:0];
  assign in_pos = s_tdata[IDX_FW+CPOS_FW-1:IDX_FW];
  assign in_val = s_tdata[IDX_FW+CPOS_FW+VAL_FW-1:IDX_FW+CPOS_FW];
  assign in_ok  = (32'(in_idx) < NUM_KEYS) && (32'(in_pos) < KEY_LEN);

  // Key table write port: clearing sweep or key character write.
  always_comb begin
    wr_en   = cmd.clr_step || (cmd.key_wr && in_ok);
    wr_addr = cmd.clr_step ? clr_cnt : {KIDX_W'(in_idx), POS_W'(in_pos)};
    wr_data = cmd.clr_step ? 8'd0 : in_val;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr] <= wr_data;
    end
    if (cmd.key_rd) begin
      rd_a <= key_mem[{kcnt, POS_W'(0)}];
      rd_b <= key_mem[{kcnt, word_pos[POS_W-1:0]}];
    end
  end

  // Counter memory read and update.
  assign ctr_addr = cmd.rd_item ? KIDX_W'(item_idx) : kcnt;
  assign hit = still[kcnt] && (rd_a != 8'd0) &&
               ((32'(word_pos) == KEY_LEN) || (rd_b == 8'd0));

  always_ff @(posedge clk) begin
    if (cmd.ctr_rd) begin
      ctr_q <= ctr_vld[ctr_addr] ? ctr_mem[ctr_addr] : '0;
    end
    if (cmd.cls_upd && hit && (ctr_q != '1)) begin
      ctr_mem[kcnt] <= ctr_q + 1'b1;
    end
  end

  // Control-side registers of the datapath.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctr_vld  <= '0;
      still    <= '1;
      word_pos <= '0;
      kcnt     <= '0;
      clr_cnt  <= '0;
    end else begin
      if (cmd.ctr_clr) begin
        ctr_vld <= '0;
      end else if (cmd.cls_upd && hit && (ctr_q != '1)) begin
        ctr_vld[kcnt] <= 1'b1;
      end
      if (cmd.restart) begin
        still    <= '1;
        word_pos <= '0;
      end else begin
        if (cmd.kill_all) begin
          still <= '0;
        end else if (cmd.ltr_cmp) begin
          still[kcnt] <= still[kcnt] && (rd_b != 8'd0) && (fold_case(rd_b) == letter);
        end
        if (cmd.word_inc) begin
          word_pos <= word_pos + 1'b1;
        end
      end
      if (cmd.k_clr) begin
        kcnt <= '0;
      end else if (cmd.k_inc) begin
        kcnt <= kcnt + 1'b1;
      end
      if (cmd.clr_step) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
    end
  end

  // Item latch taken on every accepted beat.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      letter   <= fold_case(in_val);
      item_idx <= in_idx;
      item_oob <= !(32'(in_idx) < NUM_KEYS);
    end
  end

  always_comb begin
    sts.kind       = s_tuser;
    sts.is_letter  = ((in_val >= 8'd65) && (in_val <= 8'd90)) ||
                     ((in_val >= 8'd97) && (in_val <= 8'd122));
    sts.word_empty = (word_pos == '0);
    sts.word_full  = (32'(word_pos) >= KEY_LEN);
    sts.last_key   = (kcnt == KIDX_W'(NUM_KEYS - 1));
    sts.clr_last   = (clr_cnt == '1);
  end

  // Result register: holds the beat while the receiver stalls, so the
  // counter read path stays free for word closes.
  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      m_tdata <= {1'b0, (item_oob ? {CNT_W{1'b0}} : ctr_q), item_idx};
    end
  end

endmodule
`default_nettype wire

// ===== sv/koc_ctrl.sv =====
`default_nettype none
module koc_ctrl
  import koc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     s_tvalid,
  output logic          s_tready,
  output logic          m_tvalid,
  input  wire logic     m_tready,
  input  wire koc_sts_t sts,
  output koc_cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_LTR_RD, S_LTR_CMP, S_CLS_RD, S_CLS_UPD, S_CNT_RD, S_OUT
  } state_t;

  state_t state, state_next;
  logic   acc;
  logic   out_full;

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = out_full;
  assign acc      = s_tvalid && s_tready;

  // Command decode and next state.
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (acc) begin
          cmd.accept = 1'b1;
          cmd.k_clr  = 1'b1;
          case (sts.kind)
            KIND_KEY_WR: cmd.key_wr = 1'b1;
            KIND_TEXT: begin
              if (sts.is_letter) begin
                if (sts.word_full) begin
                  cmd.kill_all = 1'b1;
                end else begin
                  state_next = S_LTR_RD;
                end
              end else if (sts.word_empty) begin
                cmd.restart = 1'b1;
              end else begin
                state_next = S_CLS_RD;
              end
            end
            KIND_EOT: begin
              if (sts.word_empty) begin
                cmd.restart = 1'b1;
              end else begin
                state_next = S_CLS_RD;
              end
            end
            KIND_RD_CNT: state_next = S_CNT_RD;
            KIND_CLR:    cmd.ctr_clr = 1'b1;
            default: ;
          endcase
        end
      end
      S_LTR_RD: begin
        cmd.key_rd = 1'b1;
        state_next = S_LTR_CMP;
      end
      S_LTR_CMP: begin
        cmd.ltr_cmp = 1'b1;
        if (sts.last_key) begin
          cmd.word_inc = 1'b1;
          state_next   = S_IDLE;
        end else begin
          cmd.k_inc  = 1'b1;
          state_next = S_LTR_RD;
        end
      end
      S_CLS_RD: begin
        cmd.key_rd = 1'b1;
        cmd.ctr_rd = 1'b1;
        state_next = S_CLS_UPD;
      end
      S_CLS_UPD: begin
        cmd.cls_upd = 1'b1;
        if (sts.last_key) begin
          cmd.restart = 1'b1;
          state_next  = S_IDLE;
        end else begin
          cmd.k_inc  = 1'b1;
          state_next = S_CLS_RD;
        end
      end
      S_CNT_RD: begin
        cmd.ctr_rd  = 1'b1;
        cmd.rd_item = 1'b1;
        state_next  = S_OUT;
      end
      S_OUT: begin
        // Load the result register once it is empty or being drained.
        if (!out_full || m_tready) begin
          cmd.out_ld = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      out_full <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_ld) begin
        out_full <= 1'b1;
      end else if (m_tready) begin
        out_full <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
`default_nettype none
module testbench;
  import koc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Kinds that the block accepts and ignores.
  localparam logic [KIND_FW-1:0] KIND_SPARE_A = 3'd5;
  localparam logic [KIND_FW-1:0] KIND_SPARE_C = 3'd7;
  localparam int TARGET_ITEMS = 650;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 700;

  // Shadow of the key table and counters; predicts every count read.
  class count_board;
    logic [7:0]  key_tab[NUM_KEYS][KEY_LEN];
    bit          alive[NUM_KEYS];
    int unsigned word_len;
    logic [31:0] tally[NUM_KEYS];
    logic [6:0]  want_slot[$];
    logic [31:0] want_count[$];
    int          errors;
    int          checked;
    int          words_closed;

    function new();
      foreach (key_tab[k, p]) key_tab[k][p] = 8'd0;
      foreach (tally[k]) tally[k] = 32'd0;
      restart();
    endfunction

    function automatic logic [7:0] folded(logic [7:0] c);
      return (c > 8'd90) ? c - 8'd32 : c;
    endfunction

    function automatic bit letter(logic [7:0] c);
      return (c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122);
    endfunction

    function void restart();
      foreach (alive[k]) alive[k] = 1'b1;
      word_len = 0;
    endfunction

    function void close_word();
      bit ends;
      if (word_len > 0) begin
        words_closed++;
        for (int k = 0; k < NUM_KEYS; k++) begin
          if (alive[k] && key_tab[k][0] != 8'd0) begin
            ends = (word_len >= KEY_LEN) || (key_tab[k][word_len] == 8'd0);
            if (ends && tally[k] != 32'hFFFF_FFFF) tally[k]++;
          end
        end
      end
      restart();
    endfunction

    // Apply one accepted input beat to the shadow state.
    function void note_beat(logic [2:0] kind, logic [6:0] slot, logic [4:0] pos,
                            logic [7:0] val);
      case (kind)
        KIND_KEY_WR: key_tab[slot][pos] = val;
        KIND_TEXT: begin
          if (!letter(val)) begin
            close_word();
          end else if (word_len >= KEY_LEN) begin
            foreach (alive[k]) alive[k] = 1'b0;
          end else begin
            for (int k = 0; k < NUM_KEYS; k++)
              if (key_tab[k][word_len] == 8'd0 ||
                  folded(key_tab[k][word_len]) != folded(val))
                alive[k] = 1'b0;
            word_len++;
          end
        end
        KIND_EOT: close_word();
        KIND_RD_CNT: begin
          want_slot.push_back(slot);
          want_count.push_back(tally[slot]);
        end
        KIND_CLR: foreach (tally[k]) tally[k] = 32'd0;
        default: ;
      endcase
    endfunction

    task report(string what);
      $display("MISMATCH at %0t: %s", $time, what);
      errors++;
    endtask

    // Compare one result beat with the oldest pending count read.
    task check_beat(logic [6:0] slot, logic [31:0] cnt);
      logic [6:0]  es;
      logic [31:0] ec;
      checked++;
      if (want_slot.size() == 0) begin
        report($sformatf("unexpected result slot %0d count %0d", slot, cnt));
        return;
      end
      es = want_slot.pop_front();
      ec = want_count.pop_front();
      if (slot !== es) report($sformatf("slot %0d, expected %0d", slot, es));
      if (cnt !== ec)
        report($sformatf("slot %0d count %0d, expected %0d", es, cnt, ec));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_TW-1:0] s_tdata = '0;
  logic [KIND_FW-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_TW-1:0] m_tdata;

  count_board board = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_asked = 0;
  int hold_served = 0;
  int hold_left = 0;
  int items_sent = 0;
  int overlong_left = 3;
  string slot_word[NUM_KEYS];
  int loaded[$];

  always #5 clk = ~clk;

  keyword_occurrence_counter_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  // Result side: random stalls, plus a long hold-off when one is asked for.
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_asked != hold_served) begin
      hold_served = hold_asked;
      hold_left = HOLD_CYCLES;
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Check every result beat as it is taken.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_beat(m_tdata[6:0], m_tdata[38:7]);
  end

  // Offer one beat, with random gaps, and wait for it to be taken.
  task automatic send(logic [2:0] kind, logic [6:0] slot, logic [4:0] pos,
                      logic [7:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= {4'd0, val, pos, slot};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.note_beat(kind, slot, pos, val);
    if (kind <= KIND_CLR) items_sent++;
    @(negedge clk);
  endtask

  task automatic load_key(int slot, string w);
    for (int i = 0; i < w.len() && i < KEY_LEN; i++) send(KIND_KEY_WR, slot, i, w[i]);
    if (w.len() < KEY_LEN) send(KIND_KEY_WR, slot, w.len(), 8'd0);
    slot_word[slot] = w;
    loaded.push_back(slot);
  endtask

  // Send a word's letters with random case, then close it.
  task automatic say_word(string w);
    logic [7:0] c;
    for (int i = 0; i < w.len(); i++) begin
      c = w[i];
      if (board.letter(c) && $urandom_range(1)) c ^= 8'h20;
      send(KIND_TEXT, $urandom, $urandom, c);
    end
    close_any();
  endtask

  task automatic close_any();
    logic [7:0] c;
    if ($urandom_range(3) == 0) begin
      send(KIND_EOT, $urandom, $urandom, $urandom);
    end else begin
      do c = $urandom_range(255); while (board.letter(c));
      send(KIND_TEXT, $urandom, $urandom, c);
    end
  endtask

  function automatic string random_word(int len);
    string w = "";
    logic [7:0] c;
    for (int i = 0; i < len; i++) begin
      c = $urandom_range(1) ? 8'(65 + $urandom_range(25)) : 8'(97 + $urandom_range(25));
      w = {w, string'(c)};
    end
    return w;
  endfunction

  task automatic read_slot(int slot);
    send(KIND_RD_CNT, slot, $urandom, $urandom);
  endtask

  initial begin
    int r;
    int slot;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part: key edge cases, every defined kind, and a long result stall.
    load_key(0, "the");
    load_key(1, "THE");
    load_key(127, "yz");
    load_key(9, "a{b");
    load_key(64, "qwertyuiopasdfghjklzxcvbnmQWERTY");
    send(KIND_KEY_WR, 3, 0, 8'd0);
    send(KIND_TEXT, 0, 0, 8'd32);
    say_word("The");
    say_word("yZ");
    say_word("qwertyuiopasdfghjklzxcvbnmQWERTY");
    say_word("theX");
    send(KIND_EOT, 0, 0, 0);
    send(KIND_SPARE_A, 7'h7F, 5'h1F, 8'hFF);
    send(KIND_SPARE_C, 0, 0, 0);
    hold_asked++;
    for (int i = 0; i < 12; i++) read_slot(i < 4 ? loaded[i] : $urandom_range(127));
    send(KIND_CLR, 0, 0, 0);
    read_slot(0);

    // Random part, in three stall phases.
    while (items_sent < TARGET_ITEMS) begin
      send_idle_pct = (items_sent < 217) ? 18 : (items_sent < 434) ? 88 : 0;
      recv_idle_pct = (items_sent < 217) ? 88 : (items_sent < 434) ? 18 : 0;
      r = $urandom_range(99);
      slot = loaded[$urandom_range(loaded.size() - 1)];
      if (r < 45) begin
        say_word(slot_word[slot]);
      end else if (r < 55) begin
        say_word(random_word($urandom_range(1, 6)));
      end else if (r < 72) begin
        read_slot($urandom_range(3) != 0 ? slot : $urandom_range(127));
      end else if (r < 78) begin
        slot = $urandom_range(127);
        if ($urandom_range(4) == 0) send(KIND_KEY_WR, slot, 0, 8'd0);
        else load_key(slot, random_word($urandom_range(1, 5)));
      end else if (r < 81) begin
        send(KIND_CLR, $urandom, $urandom, $urandom);
      end else if (r < 84) begin
        send($urandom_range(KIND_SPARE_A, KIND_SPARE_C), $urandom, $urandom, $urandom);
      end else if (r < 92) begin
        send(KIND_TEXT, $urandom, $urandom, $urandom);
      end else if (r < 94 && overlong_left > 0) begin
        overlong_left--;
        say_word(random_word(KEY_LEN + $urandom_range(1, 2)));
      end else begin
        send(KIND_KEY_WR, $urandom, $urandom, $urandom);
      end
    end
    for (int i = 0; i < loaded.size(); i++) read_slot(loaded[i]);
    s_tvalid <= 1'b0;

    // Drain: wait for every pending read, then let the block settle.
    while (board.want_slot.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d input beats, %0d words closed, %0d count reads checked.",
             items_sent, board.words_closed, board.checked);
    if (board.errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #40ms;
    $display("Timeout with %0d reads outstanding.", board.want_slot.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
`default_nettype wire
